### src/pdb_pkg.sv
// Shared constants for the pointer delta ballistics block.
`default_nettype none

package pdb_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 12;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_Y    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_EN    = CFG_IDX_W'(3);

  // Register widths and reset values.
  localparam int unsigned SENS_W = 12;
  localparam int unsigned DZ_W   = 12;
  localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(256);

  // Acceleration curve: knee at 5.0 in Q8, slope 0.01 per unit of distance in Q16.
  localparam int unsigned ACCEL_KNEE  = 1280;
  localparam int unsigned ACCEL_SLOPE = 655;
  localparam int unsigned UNITY_Q16   = 65536;

  // Result width.
  localparam int unsigned OUT_W = 16;

endpackage

`default_nettype wire

### src/pdb_isqrt.sv
// Pipelined integer square root, one root bit resolved per stage.
`default_nettype none

module pdb_isqrt #(
  parameter int unsigned ROOT_W = 20
) (
  input  wire logic                  clk_i,
  input  wire logic [2*ROOT_W-1:0]   rad_i,
  output logic      [ROOT_W-1:0]     root_o
);

  // Partial remainder and remaining radicand bits travel with each beat.
  logic [ROOT_W+1:0]   rem_q  [ROOT_W-1];
  logic [2*ROOT_W-1:0] rad_q  [ROOT_W-1];
  logic [ROOT_W-1:0]   root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [ROOT_W+1:0]   rem_in;
    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;
    logic [ROOT_W+1:0]   rem_nx;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] rad_in;
    logic                take;

    // Stage inputs come from the port or from the previous stage.
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign rem_sh = {rem_in[ROOT_W-1:0], rad_in[2*ROOT_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign take   = (rem_sh >= trial);
    assign rem_nx = take ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk_i) begin
      root_q[k] <= {root_in[ROOT_W-2:0], take};
    end

    // The last stage needs no remainder or radicand for a later step.
    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k] <= rem_nx;
        rad_q[k] <= {rad_in[2*ROOT_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

`default_nettype wire

### src/pdb_lane.sv
// One axis lane: square, sensitivity gain, acceleration gain and saturation.
`default_nettype none

module pdb_lane #(
  parameter int unsigned COUNT_WIDTH = 12,
  parameter int unsigned DELAY       = 22,
  parameter int unsigned FACT_W      = 23
) (
  input  wire logic                                clk_i,
  input  wire logic signed [COUNT_WIDTH-1:0]       d_i,
  input  wire logic        [pdb_pkg::SENS_W-1:0]   sens_i,
  input  wire logic                                flip_i,
  input  wire logic        [FACT_W-1:0]            factor_i,
  input  wire logic                                zero_i,
  output logic             [2*COUNT_WIDTH-1:0]     sq_o,
  output logic signed      [pdb_pkg::OUT_W-1:0]    sat_o
);

  import pdb_pkg::*;

  localparam int unsigned CW     = COUNT_WIDTH;
  localparam int unsigned SCL_W  = CW + 4;
  localparam int unsigned GAIN_W = CW + SENS_W;
  localparam int unsigned PROD_W = SCL_W + FACT_W;
  localparam int unsigned ACC_W  = PROD_W - 16;
  localparam int unsigned AX_W   = (ACC_W > OUT_W + 1) ? ACC_W : OUT_W + 1;

  logic signed [CW-1:0]     d_q;
  logic        [CW-1:0]     d_u;
  logic                     neg;
  logic        [CW-1:0]     mag;
  logic        [GAIN_W-1:0] gain_prod;
  logic        [2*CW-1:0]   sq_q;
  logic        [SCL_W-1:0]  scl_q;
  logic                     neg_q;
  logic        [SCL_W-1:0]  scl_dl [DELAY];
  logic                     neg_dl [DELAY];
  logic        [PROD_W-1:0] accel_prod;
  logic        [ACC_W-1:0]  acc_q;
  logic                     acc_neg_q;
  logic                     zero_q;
  logic        [AX_W-1:0]   acc_x;

  // Input register for the axis count.
  always_ff @(posedge clk_i) begin
    d_q <= d_i;
  end

  // Sign and magnitude; the magnitude of the most negative count still fits.
  assign d_u = d_q;
  assign neg = d_q[CW-1];
  assign mag = neg ? (~d_u + 1'b1) : d_u;
  assign gain_prod = GAIN_W'(mag) * GAIN_W'(sens_i);

  // Square for the distance and Q8 sensitivity gain, truncated toward zero.
  always_ff @(posedge clk_i) begin
    sq_q  <= (2*CW)'(mag) * (2*CW)'(mag);
    scl_q <= gain_prod[GAIN_W-1:8];
    neg_q <= neg ^ flip_i;
  end

  assign sq_o = sq_q;

  // Hold the scaled magnitude while the distance is computed.
  always_ff @(posedge clk_i) begin
    scl_dl[0] <= scl_q;
    neg_dl[0] <= neg_q;
    for (int i = 1; i < DELAY; i++) begin
      scl_dl[i] <= scl_dl[i-1];
      neg_dl[i] <= neg_dl[i-1];
    end
  end

  // Q16 acceleration gain, truncated toward zero.
  assign accel_prod = PROD_W'(scl_dl[DELAY-1]) * PROD_W'(factor_i);

  always_ff @(posedge clk_i) begin
    acc_q     <= accel_prod[PROD_W-1:16];
    acc_neg_q <= neg_dl[DELAY-1];
    zero_q    <= zero_i;
  end

  // Apply the sign and saturate to the signed output range.
  assign acc_x = AX_W'(acc_q);

  always_comb begin
    priority if (zero_q) begin
      sat_o = '0;
    end else if (acc_neg_q) begin
      if (acc_x > AX_W'(32768)) begin
        sat_o = OUT_W'(16'sh8000);
      end else begin
        sat_o = OUT_W'(~acc_x[OUT_W-1:0] + 1'b1);
      end
    end else begin
      if (acc_x > AX_W'(32767)) begin
        sat_o = OUT_W'(16'sh7fff);
      end else begin
        sat_o = acc_x[OUT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

### src/pointer_delta_ballistics_top.sv
// Top level of the pointer delta ballistics block.
`default_nettype none

// Shapes one raw pointer motion report (raw_dx_i, raw_dy_i) into one output
// motion. A report is taken on every clock edge where start is high; busy is
// always low, so a new report may follow in every cycle. Each result appears
// on out_dx_o / out_dy_o for exactly one cycle with out_valid_o high, in
// report order. The receiver cannot stall the block, so a result must be
// captured in the cycle it is shown. The square root pipeline resolves one
// bit of the Q8 distance per stage. Write the configuration registers only
// while no report is in flight.
module pointer_delta_ballistics_top #(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [COUNT_WIDTH-1:0]        raw_dx_i,
  input  wire logic signed [COUNT_WIDTH-1:0]        raw_dy_i,
  output logic                                      out_valid_o,
  output logic signed      [pdb_pkg::OUT_W-1:0]     out_dx_o,
  output logic signed      [pdb_pkg::OUT_W-1:0]     out_dy_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic        [pdb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [pdb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import pdb_pkg::*;

  localparam int unsigned CW       = COUNT_WIDTH;
  localparam int unsigned ROOT_W   = CW + 8;
  localparam int unsigned FACT_W   = ROOT_W + 3;
  localparam int unsigned SLOPE_W  = ROOT_W + 10;
  localparam int unsigned DELAY    = ROOT_W + 2;
  localparam int unsigned PIPE_LEN = ROOT_W + 6;

  logic [SENS_W-1:0]     sens_q;
  logic [DZ_W-1:0]       dz_q;
  logic                  inv_q;
  logic                  accel_q;
  logic                  cfg_we;
  logic [PIPE_LEN-1:0]   vld_q;
  logic [2*CW-1:0]       sq_x;
  logic [2*CW-1:0]       sq_y;
  logic [2*CW-1:0]       sum_q;
  logic [2*ROOT_W-1:0]   rad;
  logic [ROOT_W-1:0]     dist_q8;
  logic [SLOPE_W-1:0]    slope_prod;
  logic                  over_knee;
  logic [FACT_W-1:0]     factor_d;
  logic [FACT_W-1:0]     factor_q;
  logic                  zero_d;
  logic                  zero_q;
  logic signed [OUT_W-1:0] sat_x;
  logic signed [OUT_W-1:0] sat_y;

  // Never busy: every cycle with start high takes a report.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q  <= SENS_RESET;
      dz_q    <= '0;
      inv_q   <= 1'b0;
      accel_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_SENSITIVITY: sens_q  <= cfg_data_i[SENS_W-1:0];
        REG_DEAD_ZONE:   dz_q    <= cfg_data_i[DZ_W-1:0];
        REG_INVERT_Y:    inv_q   <= cfg_data_i[0];
        REG_ACCEL_EN:    accel_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Beat valid flags follow the datapath stage by stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LEN-2:0], start && !busy};
    end
  end

  // Horizontal and vertical lanes work side by side.
  pdb_lane #(
    .COUNT_WIDTH (CW),
    .DELAY       (DELAY),
    .FACT_W      (FACT_W)
  ) u_lane_x (
    .clk_i    (clk_i),
    .d_i      (raw_dx_i),
    .sens_i   (sens_q),
    .flip_i   (1'b0),
    .factor_i (factor_q),
    .zero_i   (zero_q),
    .sq_o     (sq_x),
    .sat_o    (sat_x)
  );

  pdb_lane #(
    .COUNT_WIDTH (CW),
    .DELAY       (DELAY),
    .FACT_W      (FACT_W)
  ) u_lane_y (
    .clk_i    (clk_i),
    .d_i      (raw_dy_i),
    .sens_i   (sens_q),
    .flip_i   (inv_q),
    .factor_i (factor_q),
    .zero_i   (zero_q),
    .sq_o     (sq_y),
    .sat_o    (sat_y)
  );

  // Sum of squares from both lanes; each square is at most 2^(2*CW-2).
  always_ff @(posedge clk_i) begin
    sum_q <= sq_x + sq_y;
  end

  // Q8 distance: square root of the sum shifted up by sixteen.
  assign rad = {sum_q, 16'b0};

  pdb_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (rad),
    .root_o (dist_q8)
  );

  // Dead zone test and acceleration factor from the distance.
  assign over_knee  = (dist_q8 > ROOT_W'(ACCEL_KNEE));
  assign slope_prod = SLOPE_W'(dist_q8 - ROOT_W'(ACCEL_KNEE)) * SLOPE_W'(ACCEL_SLOPE);
  assign zero_d     = (dist_q8 < ROOT_W'(dz_q));
  assign factor_d   = (accel_q && over_knee)
                    ? FACT_W'(UNITY_Q16) + FACT_W'(slope_prod[SLOPE_W-1:8])
                    : FACT_W'(UNITY_Q16);

  always_ff @(posedge clk_i) begin
    factor_q <= factor_d;
    zero_q   <= zero_d;
  end

  // Output register with its strobe.
  always_ff @(posedge clk_i) begin
    out_dx_o <= sat_x;
    out_dy_o <= sat_y;
  end

  assign out_valid_o = vld_q[PIPE_LEN-1];

endmodule

`default_nettype wire
